// ----- rtl/lrp_pkg.sv -----
package lrp_pkg;

    // default sizes
    localparam int DEF_MAX_STATES       = 256;
    localparam int DEF_MAX_TERMINALS    = 64;
    localparam int DEF_MAX_NONTERMINALS = 64;
    localparam int DEF_MAX_PRODUCTIONS  = 256;
    localparam int DEF_STACK_DEPTH      = 64;
    localparam int DEF_MAX_RHS          = 15;

    // fixed field widths
    localparam int KIND_W = 3;
    localparam int VAL_W  = 8;
    localparam int COL_W  = 6;
    localparam int EK_W   = 2;
    localparam int LEN_W  = 4;
    localparam int LINE_W = 16;
    localparam int STS_W  = 3;
    localparam int RED_W  = 7;
    localparam int ACT_W  = EK_W + VAL_W;
    localparam int PROD_W = LEN_W + VAL_W;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ACTION = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GOTO   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PROD   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TOKEN  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_START  = 3'd4;

    // action entry kinds
    localparam logic [EK_W-1:0] ACT_ERROR  = 2'd0;
    localparam logic [EK_W-1:0] ACT_SHIFT  = 2'd1;
    localparam logic [EK_W-1:0] ACT_REDUCE = 2'd2;
    localparam logic [EK_W-1:0] ACT_ACCEPT = 2'd3;

    // result status codes
    localparam logic [STS_W-1:0] STS_SHIFTED  = 3'd0;
    localparam logic [STS_W-1:0] STS_ACCEPTED = 3'd1;
    localparam logic [STS_W-1:0] STS_SYNTAX   = 3'd2;
    localparam logic [STS_W-1:0] STS_LEXICAL  = 3'd3;
    localparam logic [STS_W-1:0] STS_STACK    = 3'd4;
    localparam logic [STS_W-1:0] STS_IDLE     = 3'd5;

    localparam logic [VAL_W-1:0] START_STATE     = 8'd1;
    localparam logic [RED_W-1:0] REDUCTION_LIMIT = 7'd64;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACT,
        S_PROD,
        S_STK,
        S_GOTO
    } state_t;

    typedef struct packed {
        logic             clr_step;
        logic             wr_action;
        logic             wr_goto;
        logic             wr_prod;
        logic             start_parse;
        logic             tok_issue;
        logic             shift_push;
        logic             prod_issue;
        logic             stk_issue;
        logic             goto_issue;
        logic             goto_push;
        logic             fin;
        logic             fin_in;
        logic [STS_W-1:0] fin_status;
    } cmd_t;

    typedef struct packed {
        logic            clr_last;
        logic            active;
        logic [EK_W-1:0] act_kind;
        logic            reduce_bad;
        logic            shift_full;
        logic            len_under;
        logic            push_full;
    } sts_t;

endpackage

// ----- rtl/lrp_ram.sv -----
module lrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/lrp_ctrl.sv -----
module lrp_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lrp_pkg::KIND_W-1:0]  kind,
    input  logic                        lex_error,
    input  lrp_pkg::sts_t               sts,
    output lrp_pkg::cmd_t               cmd,
    output logic                        busy
);

    import lrp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    case (kind)
                        KIND_ACTION: cmd.wr_action   = 1'b1;
                        KIND_GOTO:   cmd.wr_goto     = 1'b1;
                        KIND_PROD:   cmd.wr_prod     = 1'b1;
                        KIND_START:  cmd.start_parse = 1'b1;
                        KIND_TOKEN:
                        begin
                            if (!sts.active)
                            begin
                                cmd.fin        = 1'b1;
                                cmd.fin_in     = 1'b1;
                                cmd.fin_status = STS_IDLE;
                            end
                            else if (lex_error)
                            begin
                                cmd.fin        = 1'b1;
                                cmd.fin_in     = 1'b1;
                                cmd.fin_status = STS_LEXICAL;
                            end
                            else
                            begin
                                cmd.tok_issue = 1'b1;
                                state_next    = S_ACT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ACT:
            begin
                case (sts.act_kind)
                    ACT_ACCEPT:
                    begin
                        cmd.fin        = 1'b1;
                        cmd.fin_status = STS_ACCEPTED;
                        state_next     = S_IDLE;
                    end
                    ACT_SHIFT:
                    begin
                        cmd.fin = 1'b1;
                        if (sts.shift_full)
                        begin
                            cmd.fin_status = STS_STACK;
                        end
                        else
                        begin
                            cmd.shift_push = 1'b1;
                            cmd.fin_status = STS_SHIFTED;
                        end
                        state_next = S_IDLE;
                    end
                    ACT_REDUCE:
                    begin
                        if (sts.reduce_bad)
                        begin
                            cmd.fin        = 1'b1;
                            cmd.fin_status = STS_SYNTAX;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            cmd.prod_issue = 1'b1;
                            state_next     = S_PROD;
                        end
                    end
                    default:
                    begin
                        cmd.fin        = 1'b1;
                        cmd.fin_status = STS_SYNTAX;
                        state_next     = S_IDLE;
                    end
                endcase
            end
            S_PROD:
            begin
                if (sts.len_under || sts.push_full)
                begin
                    cmd.fin        = 1'b1;
                    cmd.fin_status = STS_STACK;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.stk_issue = 1'b1;
                    state_next    = S_STK;
                end
            end
            S_STK:
            begin
                cmd.goto_issue = 1'b1;
                state_next     = S_GOTO;
            end
            S_GOTO:
            begin
                // push goto state and look up the next action right away
                cmd.goto_push = 1'b1;
                state_next    = S_ACT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |=> state_reg == S_IDLE)
        else $error("result issued without return to idle");

    a_tok_active: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tok_issue |-> sts.active)
        else $error("table walk started with no parse active");

    a_clear_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !sts.active)
        else $error("parse active during table clear");
`endif

endmodule

// ----- rtl/lrp_dp.sv -----
module lrp_dp #(
    parameter int MAX_STATES       = lrp_pkg::DEF_MAX_STATES,
    parameter int MAX_TERMINALS    = lrp_pkg::DEF_MAX_TERMINALS,
    parameter int MAX_NONTERMINALS = lrp_pkg::DEF_MAX_NONTERMINALS,
    parameter int MAX_PRODUCTIONS  = lrp_pkg::DEF_MAX_PRODUCTIONS,
    parameter int STACK_DEPTH      = lrp_pkg::DEF_STACK_DEPTH,
    parameter int MAX_RHS          = lrp_pkg::DEF_MAX_RHS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lrp_pkg::cmd_t               cmd,
    output lrp_pkg::sts_t               sts,
    input  logic [lrp_pkg::VAL_W-1:0]   row,
    input  logic [lrp_pkg::COL_W-1:0]   column,
    input  logic [lrp_pkg::EK_W-1:0]    entry_kind,
    input  logic [lrp_pkg::VAL_W-1:0]   entry_value,
    input  logic [lrp_pkg::LEN_W-1:0]   entry_length,
    input  logic [lrp_pkg::COL_W-1:0]   terminal_code,
    input  logic [lrp_pkg::LINE_W-1:0]  token_line,
    output logic                        done,
    output logic [lrp_pkg::STS_W-1:0]   status,
    output logic [lrp_pkg::VAL_W-1:0]   top_state,
    output logic [lrp_pkg::RED_W-1:0]   reductions_done,
    output logic [lrp_pkg::LINE_W-1:0]  error_line
);

    import lrp_pkg::*;

    localparam int ACT_DEPTH  = MAX_STATES * MAX_TERMINALS;
    localparam int GOTO_DEPTH = MAX_STATES * MAX_NONTERMINALS;
    localparam int CLR_DEPTH  = (ACT_DEPTH > GOTO_DEPTH) ? ACT_DEPTH : GOTO_DEPTH;
    localparam int ACT_AW     = $clog2(ACT_DEPTH);
    localparam int GOTO_AW    = $clog2(GOTO_DEPTH);
    localparam int CLR_AW     = $clog2(CLR_DEPTH);
    localparam int PROD_AW    = $clog2(MAX_PRODUCTIONS);
    localparam int STK_AW     = $clog2(STACK_DEPTH);
    localparam int SP_W       = $clog2(STACK_DEPTH + 1);
    localparam int AIDX_W     = VAL_W + $clog2(MAX_TERMINALS + 1) + 1;
    localparam int GIDX_W     = VAL_W + $clog2(MAX_NONTERMINALS + 1) + 1;

    // control state
    logic [CLR_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [VAL_W-1:0]  top_reg, top_next;
    logic              active_reg, active_next;
    logic              done_reg, done_next;

    // payload
    logic [RED_W-1:0]  red_reg, red_next;
    logic [COL_W-1:0]  term_reg, term_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [VAL_W-1:0]  left_reg, left_next;
    logic              act_oob_reg, act_oob_next;
    logic              goto_oob_reg, goto_oob_next;
    logic [STS_W-1:0]  status_reg, status_next;
    logic [VAL_W-1:0]  top_out_reg, top_out_next;
    logic [RED_W-1:0]  red_out_reg, red_out_next;
    logic [LINE_W-1:0] eline_reg, eline_next;

    // memories
    logic               act_we;
    logic [ACT_AW-1:0]  act_addr;
    logic [ACT_W-1:0]   act_wdata, act_rdata;
    logic               goto_we;
    logic [GOTO_AW-1:0] goto_addr;
    logic [VAL_W-1:0]   goto_wdata, goto_rdata;
    logic               prod_we;
    logic [PROD_AW-1:0] prod_waddr, prod_raddr;
    logic [PROD_W-1:0]  prod_wdata, prod_rdata;
    logic               stk_we;
    logic [STK_AW-1:0]  stk_waddr, stk_raddr;
    logic [VAL_W-1:0]   stk_wdata, stk_rdata;

    logic [VAL_W-1:0]  act_row_sel, goto_row_sel, goto_col_sel, aval, g_val, prod_left;
    logic [COL_W-1:0]  act_col_sel;
    logic [AIDX_W-1:0] act_idx;
    logic [GIDX_W-1:0] goto_idx;
    logic              act_in_range, goto_in_range;
    logic [LEN_W-1:0]  len_sat, prod_len;
    logic [SP_W-1:0]   sp_after;

    assign aval      = act_rdata[VAL_W-1:0];
    assign g_val     = goto_oob_reg ? '0 : goto_rdata;
    assign prod_len  = prod_rdata[PROD_W-1:VAL_W];
    assign prod_left = prod_rdata[VAL_W-1:0];
    assign sp_after  = sp_reg - SP_W'(prod_len);

    // action table address: one shared row*width+column
    always_comb
    begin
        if (cmd.wr_action)
        begin
            act_row_sel = row;
            act_col_sel = column;
        end
        else if (cmd.goto_push)
        begin
            act_row_sel = g_val;
            act_col_sel = term_reg;
        end
        else
        begin
            act_row_sel = top_reg;
            act_col_sel = terminal_code;
        end
        act_idx = AIDX_W'(act_row_sel) * AIDX_W'(MAX_TERMINALS) + AIDX_W'(act_col_sel);
        act_in_range = (32'(act_row_sel) < MAX_STATES) && (32'(act_col_sel) < MAX_TERMINALS);
        act_addr  = cmd.clr_step ? ACT_AW'(clr_cnt_reg) : ACT_AW'(act_idx);
        act_we    = (cmd.clr_step && (32'(clr_cnt_reg) < ACT_DEPTH))
                    || (cmd.wr_action && act_in_range);
        act_wdata = cmd.clr_step ? '0 : {entry_kind, entry_value};
    end

    always_comb
    begin
        if (cmd.wr_goto)
        begin
            goto_row_sel = row;
            goto_col_sel = VAL_W'(column);
        end
        else
        begin
            goto_row_sel = stk_rdata;
            goto_col_sel = left_reg;
        end
        goto_idx = GIDX_W'(goto_row_sel) * GIDX_W'(MAX_NONTERMINALS) + GIDX_W'(goto_col_sel);
        goto_in_range = (32'(goto_row_sel) < MAX_STATES)
                        && (32'(goto_col_sel) < MAX_NONTERMINALS);
        goto_addr  = cmd.clr_step ? GOTO_AW'(clr_cnt_reg) : GOTO_AW'(goto_idx);
        goto_we    = (cmd.clr_step && (32'(clr_cnt_reg) < GOTO_DEPTH))
                     || (cmd.wr_goto && goto_in_range);
        goto_wdata = cmd.clr_step ? '0 : entry_value;
    end

    always_comb
    begin
        len_sat    = (32'(entry_length) > MAX_RHS) ? LEN_W'(MAX_RHS) : entry_length;
        prod_we    = cmd.wr_prod && (32'(row) < MAX_PRODUCTIONS);
        prod_waddr = PROD_AW'(row);
        prod_wdata = {len_sat, entry_value};
        prod_raddr = PROD_AW'(aval);
    end

    always_comb
    begin
        stk_we    = cmd.start_parse || cmd.shift_push || cmd.goto_push;
        stk_waddr = cmd.start_parse ? '0 : STK_AW'(sp_reg);
        if (cmd.start_parse)
        begin
            stk_wdata = START_STATE;
        end
        else if (cmd.shift_push)
        begin
            stk_wdata = aval;
        end
        else
        begin
            stk_wdata = g_val;
        end
        // new top after popping the right side
        stk_raddr = STK_AW'(sp_after - SP_W'(1));
    end

    always_comb
    begin
        sts.clr_last   = (32'(clr_cnt_reg) == CLR_DEPTH - 1);
        sts.active     = active_reg;
        sts.act_kind   = act_oob_reg ? ACT_ERROR : act_rdata[ACT_W-1:VAL_W];
        sts.reduce_bad = (red_reg >= REDUCTION_LIMIT) || (32'(aval) >= MAX_PRODUCTIONS);
        sts.shift_full = (32'(sp_reg) >= STACK_DEPTH);
        sts.len_under  = (32'(prod_len) >= 32'(sp_reg));
        sts.push_full  = (32'(sp_after) >= STACK_DEPTH);
    end

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        sp_next       = sp_reg;
        top_next      = top_reg;
        active_next   = active_reg;
        done_next     = 1'b0;
        red_next      = red_reg;
        term_next     = term_reg;
        line_next     = line_reg;
        left_next     = left_reg;
        act_oob_next  = act_oob_reg;
        goto_oob_next = goto_oob_reg;
        status_next   = status_reg;
        top_out_next  = top_out_reg;
        red_out_next  = red_out_reg;
        eline_next    = eline_reg;

        if (cmd.clr_step)
        begin
            clr_cnt_next = clr_cnt_reg + CLR_AW'(1);
        end
        if (cmd.start_parse)
        begin
            sp_next     = SP_W'(1);
            top_next    = START_STATE;
            active_next = 1'b1;
        end
        if (cmd.tok_issue)
        begin
            red_next     = '0;
            term_next    = terminal_code;
            line_next    = token_line;
            act_oob_next = !act_in_range;
        end
        if (cmd.shift_push)
        begin
            sp_next  = sp_reg + SP_W'(1);
            top_next = aval;
        end
        if (cmd.stk_issue)
        begin
            sp_next   = sp_after;
            left_next = prod_left;
        end
        if (cmd.goto_issue)
        begin
            goto_oob_next = !goto_in_range;
        end
        if (cmd.goto_push)
        begin
            sp_next      = sp_reg + SP_W'(1);
            top_next     = g_val;
            red_next     = red_reg + RED_W'(1);
            act_oob_next = !act_in_range;
        end
        if (cmd.fin)
        begin
            done_next    = 1'b1;
            status_next  = cmd.fin_status;
            top_out_next = cmd.shift_push ? aval : top_reg;
            red_out_next = cmd.fin_in ? '0 : red_reg;
            if ((cmd.fin_status == STS_SYNTAX) || (cmd.fin_status == STS_LEXICAL)
                || (cmd.fin_status == STS_STACK))
            begin
                eline_next = cmd.fin_in ? token_line : line_reg;
            end
            else
            begin
                eline_next = '0;
            end
            if ((cmd.fin_status != STS_SHIFTED) && (cmd.fin_status != STS_IDLE))
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            sp_reg      <= '0;
            top_reg     <= '0;
            active_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            sp_reg      <= sp_next;
            top_reg     <= top_next;
            active_reg  <= active_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg      <= red_next;
        term_reg     <= term_next;
        line_reg     <= line_next;
        left_reg     <= left_next;
        act_oob_reg  <= act_oob_next;
        goto_oob_reg <= goto_oob_next;
        status_reg   <= status_next;
        top_out_reg  <= top_out_next;
        red_out_reg  <= red_out_next;
        eline_reg    <= eline_next;
    end

    lrp_ram #(.WIDTH(ACT_W), .DEPTH(ACT_DEPTH)) u_act_ram (
        .clk   (clk),
        .we    (act_we),
        .waddr (act_addr),
        .wdata (act_wdata),
        .raddr (act_addr),
        .rdata (act_rdata)
    );

    lrp_ram #(.WIDTH(VAL_W), .DEPTH(GOTO_DEPTH)) u_goto_ram (
        .clk   (clk),
        .we    (goto_we),
        .waddr (goto_addr),
        .wdata (goto_wdata),
        .raddr (goto_addr),
        .rdata (goto_rdata)
    );

    lrp_ram #(.WIDTH(PROD_W), .DEPTH(MAX_PRODUCTIONS)) u_prod_ram (
        .clk   (clk),
        .we    (prod_we),
        .waddr (prod_waddr),
        .wdata (prod_wdata),
        .raddr (prod_raddr),
        .rdata (prod_rdata)
    );

    lrp_ram #(.WIDTH(VAL_W), .DEPTH(STACK_DEPTH)) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign done            = done_reg;
    assign status          = status_reg;
    assign top_state       = top_out_reg;
    assign reductions_done = red_out_reg;
    assign error_line      = eline_reg;

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(sp_reg) <= STACK_DEPTH)
        else $error("stack pointer beyond stack depth");

    a_active_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> sp_reg != '0)
        else $error("parse active on an empty stack");

    a_eline_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg == STS_SHIFTED || status_reg == STS_ACCEPTED
                     || status_reg == STS_IDLE) |-> eline_reg == '0)
        else $error("error line set on a non-error result");
`endif

endmodule

// ----- rtl/lr_shift_reduce_parse_engine.sv -----
// Table-driven LR(1) shift-reduce parser. A request is taken when start is
// high and busy is low; kind selects an action, goto or production table
// write, a parse start, or a token. Writes and starts give no result. A token
// gives exactly one result: done pulses for one cycle with status, top_state,
// reductions_done and error_line, and there is no way to hold it off, so
// capture it on that cycle. With no parse active or a lexer error, done is
// registered straight from the request; otherwise the action, production,
// stack and goto lookups each pass through a registered-read RAM in turn,
// the last three once per reduction, and a reduce that stops on a stack
// underflow or overflow ends after the production lookup. Busy stays high
// during the table walk, until done pulses.
// After reset busy stays high while the action and goto tables are swept to
// error and zero.
module lr_shift_reduce_parse_engine #(
    parameter int MAX_STATES       = lrp_pkg::DEF_MAX_STATES,
    parameter int MAX_TERMINALS    = lrp_pkg::DEF_MAX_TERMINALS,
    parameter int MAX_NONTERMINALS = lrp_pkg::DEF_MAX_NONTERMINALS,
    parameter int MAX_PRODUCTIONS  = lrp_pkg::DEF_MAX_PRODUCTIONS,
    parameter int STACK_DEPTH      = lrp_pkg::DEF_STACK_DEPTH,
    parameter int MAX_RHS          = lrp_pkg::DEF_MAX_RHS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [lrp_pkg::KIND_W-1:0]  kind,
    input  logic [lrp_pkg::VAL_W-1:0]   row,
    input  logic [lrp_pkg::COL_W-1:0]   column,
    input  logic [lrp_pkg::EK_W-1:0]    entry_kind,
    input  logic [lrp_pkg::VAL_W-1:0]   entry_value,
    input  logic [lrp_pkg::LEN_W-1:0]   entry_length,
    input  logic [lrp_pkg::COL_W-1:0]   terminal_code,
    input  logic                        lex_error,
    input  logic [lrp_pkg::LINE_W-1:0]  token_line,
    output logic                        done,
    output logic [lrp_pkg::STS_W-1:0]   status,
    output logic [lrp_pkg::VAL_W-1:0]   top_state,
    output logic [lrp_pkg::RED_W-1:0]   reductions_done,
    output logic [lrp_pkg::LINE_W-1:0]  error_line
);

    import lrp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    lrp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .kind      (kind),
        .lex_error (lex_error),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy)
    );

    lrp_dp #(
        .MAX_STATES       (MAX_STATES),
        .MAX_TERMINALS    (MAX_TERMINALS),
        .MAX_NONTERMINALS (MAX_NONTERMINALS),
        .MAX_PRODUCTIONS  (MAX_PRODUCTIONS),
        .STACK_DEPTH      (STACK_DEPTH),
        .MAX_RHS          (MAX_RHS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .row             (row),
        .column          (column),
        .entry_kind      (entry_kind),
        .entry_value     (entry_value),
        .entry_length    (entry_length),
        .terminal_code   (terminal_code),
        .token_line      (token_line),
        .done            (done),
        .status          (status),
        .top_state       (top_state),
        .reductions_done (reductions_done),
        .error_line      (error_line)
    );

endmodule
